// ===== hdl/lzsd_pkg.sv =====
package lzsd_pkg;

    localparam int WINDOW_DEPTH   = 4096;
    localparam int ADDR_W         = $clog2(WINDOW_DEPTH);
    localparam int COUNT_W        = ADDR_W + 1;
    localparam int TRAILING_LIMIT = 32;
    localparam int TRAIL_W        = 6;

    // parse phases
    localparam logic [3:0] PH_HDR0  = 4'd0;
    localparam logic [3:0] PH_HDR1  = 4'd1;
    localparam logic [3:0] PH_HDR2  = 4'd2;
    localparam logic [3:0] PH_HDR3  = 4'd3;
    localparam logic [3:0] PH_EXT0  = 4'd4;
    localparam logic [3:0] PH_EXT1  = 4'd5;
    localparam logic [3:0] PH_EXT2  = 4'd6;
    localparam logic [3:0] PH_EXT3  = 4'd7;
    localparam logic [3:0] PH_FLAG  = 4'd8;
    localparam logic [3:0] PH_TOKEN = 4'd9;
    localparam logic [3:0] PH_MATCH1 = 4'd10;
    localparam logic [3:0] PH_MATCH2 = 4'd11;
    localparam logic [3:0] PH_MATCH3 = 4'd12;
    localparam logic [3:0] PH_DONE  = 4'd13;
    localparam logic [3:0] PH_ERROR = 4'd14;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADTYPE = 3'd1;
    localparam logic [2:0] ST_SMALL   = 3'd2;
    localparam logic [2:0] ST_BADSIZE = 3'd3;
    localparam logic [2:0] ST_BIG     = 3'd4;
    localparam logic [2:0] ST_OVERRUN = 3'd5;

    // commands and result kinds
    localparam logic CMD_FEED    = 1'b0;
    localparam logic CMD_PULL    = 1'b1;
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // source of the byte held in the result register
    localparam logic [1:0] SRC_LIT = 2'd0;
    localparam logic [1:0] SRC_MEM = 2'd1;
    localparam logic [1:0] SRC_FWD = 2'd2;

    typedef struct packed {
        logic              has_res;
        logic              kind;
        logic [2:0]        status;
        logic [7:0]        lit;
        logic              is_copy;
        logic [ADDR_W-1:0] raddr;
        logic [ADDR_W-1:0] waddr;
    } t_res;

endpackage

// ===== hdl/lzsd_in_if.sv =====
interface lzsd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output command, output data_byte, output last_byte,
                    input ready);
    modport sink (input valid, input command, input data_byte, input last_byte,
                  output ready);
endinterface

// ===== hdl/lzsd_out_if.sv =====
interface lzsd_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] value;
    logic [2:0] status;

    modport source (output valid, output kind, output value, output status, input ready);
    modport sink (input valid, input kind, input value, input status, output ready);
endinterface

// ===== hdl/lzsd_hist.sv =====
module lzsd_hist (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [lzsd_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                 i_wdata,
    input  logic                       i_re,
    input  logic [lzsd_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                 o_rdata
);

    logic [7:0] r_mem [lzsd_pkg::WINDOW_DEPTH];
    logic [7:0] r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== hdl/lzsd_ctrl.sv =====
module lzsd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_command,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    output lzsd_pkg::t_res      o_res
);

    logic [lzsd_pkg::ADDR_W-1:0]  r_wp, n_wp;
    logic [lzsd_pkg::COUNT_W-1:0] r_pc, n_pc;
    logic [31:0]                  r_rem, n_rem;
    logic [3:0]                   r_phase, n_phase;
    logic                         r_ext, n_ext;
    logic [7:0]                   r_flags, n_flags;
    logic [3:0]                   r_left, n_left;
    logic [23:0]                  r_tok, n_tok;
    logic [16:0]                  r_copy, n_copy;
    logic [lzsd_pkg::COUNT_W-1:0] r_dist, n_dist;
    logic [lzsd_pkg::TRAIL_W-1:0] r_trail, n_trail;
    logic [2:0]                   r_fstat, n_fstat;
    logic                         r_ended, n_ended;
    lzsd_pkg::t_res               w_res;

    // parse one transfer and work out the next state
    always_comb begin
        logic [7:0]                   b0, b1, b2;
        logic [2:0]                   k;
        logic [2:0]                   c;
        logic [16:0]                  len;
        logic [lzsd_pkg::COUNT_W-1:0] mdist;
        logic                         put;
        logic                         tok_done;

        b0 = r_tok[23:16];
        b1 = r_tok[15:8];
        b2 = r_tok[7:0];
        k = 3'd2;
        c = 3'd0;
        len = '0;
        mdist = '0;
        put = 1'b0;
        tok_done = 1'b0;

        n_wp = r_wp; n_pc = r_pc; n_rem = r_rem; n_phase = r_phase; n_ext = r_ext;
        n_flags = r_flags; n_left = r_left; n_tok = r_tok; n_copy = r_copy;
        n_dist = r_dist; n_trail = r_trail; n_fstat = r_fstat; n_ended = r_ended;

        w_res = '0;
        w_res.waddr = r_wp;
        w_res.raddr = r_wp - r_dist[lzsd_pkg::ADDR_W-1:0];

        if (i_command == lzsd_pkg::CMD_PULL) begin
            if (r_copy != '0) begin
                w_res.has_res = 1'b1;
                w_res.kind    = lzsd_pkg::KIND_DATA;
                w_res.is_copy = 1'b1;
                put    = 1'b1;
                n_copy = r_copy - 17'd1;
            end else if (r_ended) begin
                w_res.has_res = 1'b1;
                w_res.kind    = lzsd_pkg::KIND_STATUS;
                w_res.status  = r_fstat;
                n_wp = '0; n_pc = '0; n_rem = '0; n_phase = lzsd_pkg::PH_HDR0;
                n_ext = 1'b0; n_flags = '0; n_left = '0; n_tok = '0; n_copy = '0;
                n_dist = '0; n_trail = '0; n_fstat = lzsd_pkg::ST_OK; n_ended = 1'b0;
            end
        end else if (!r_ended) begin
            if (r_phase != lzsd_pkg::PH_ERROR) begin
                if (r_copy != '0) begin
                    n_fstat = lzsd_pkg::ST_OVERRUN;
                    n_phase = lzsd_pkg::PH_ERROR;
                    n_copy  = '0;
                end else begin
                    unique case (r_phase)
                        lzsd_pkg::PH_HDR0: begin
                            if (i_data_byte[7:4] != 4'h1 || i_data_byte[3:0] > 4'h1) begin
                                n_fstat = lzsd_pkg::ST_BADTYPE;
                                n_phase = lzsd_pkg::PH_ERROR;
                                n_copy  = '0;
                            end else begin
                                n_ext   = i_data_byte[0];
                                n_rem   = '0;
                                n_phase = lzsd_pkg::PH_HDR1;
                            end
                        end
                        lzsd_pkg::PH_HDR1: begin
                            n_rem[7:0] = i_data_byte;
                            n_phase    = lzsd_pkg::PH_HDR2;
                        end
                        lzsd_pkg::PH_HDR2: begin
                            n_rem[15:8] = i_data_byte;
                            n_phase     = lzsd_pkg::PH_HDR3;
                        end
                        lzsd_pkg::PH_HDR3: begin
                            n_rem[23:16] = i_data_byte;
                            n_phase = (n_rem != '0) ? lzsd_pkg::PH_FLAG : lzsd_pkg::PH_EXT0;
                        end
                        lzsd_pkg::PH_EXT0: begin
                            n_rem[7:0] = i_data_byte;
                            n_phase    = lzsd_pkg::PH_EXT1;
                        end
                        lzsd_pkg::PH_EXT1: begin
                            n_rem[15:8] = i_data_byte;
                            n_phase     = lzsd_pkg::PH_EXT2;
                        end
                        lzsd_pkg::PH_EXT2: begin
                            n_rem[23:16] = i_data_byte;
                            n_phase      = lzsd_pkg::PH_EXT3;
                        end
                        lzsd_pkg::PH_EXT3: begin
                            n_rem[31:24] = i_data_byte;
                            n_phase = (n_rem != '0) ? lzsd_pkg::PH_FLAG : lzsd_pkg::PH_DONE;
                        end
                        lzsd_pkg::PH_FLAG: begin
                            n_flags = i_data_byte;
                            n_left  = 4'd8;
                            n_phase = lzsd_pkg::PH_TOKEN;
                        end
                        lzsd_pkg::PH_TOKEN: begin
                            if (r_flags[7]) begin
                                n_tok   = {i_data_byte, 16'h0000};
                                n_phase = lzsd_pkg::PH_MATCH1;
                            end else begin
                                w_res.has_res = 1'b1;
                                w_res.kind    = lzsd_pkg::KIND_DATA;
                                w_res.lit     = i_data_byte;
                                put      = 1'b1;
                                n_rem    = r_rem - 32'd1;
                                tok_done = 1'b1;
                            end
                        end
                        lzsd_pkg::PH_MATCH1, lzsd_pkg::PH_MATCH2,
                        lzsd_pkg::PH_MATCH3: begin
                            c = 3'(r_phase - lzsd_pkg::PH_TOKEN);
                            if (!r_ext)                 k = 3'd2;
                            else if (b0[7:4] == 4'h1)   k = 3'd4;
                            else if (b0[7:4] == 4'h0)   k = 3'd3;
                            else                        k = 3'd2;
                            if (c + 3'd1 >= k) begin
                                // complete the match token
                                unique case (k)
                                    3'd4: begin
                                        len   = 17'({b0[3:0], b1, b2[7:4]}) + 17'h111;
                                        mdist = 13'({b2[3:0], i_data_byte}) + 13'd1;
                                    end
                                    3'd3: begin
                                        len   = 17'({b0[3:0], b1[7:4]}) + 17'h11;
                                        mdist = 13'({b1[3:0], i_data_byte}) + 13'd1;
                                    end
                                    default: begin
                                        len   = r_ext ? 17'(b0[7:4]) + 17'h1
                                                      : 17'(b0[7:4]) + 17'd3;
                                        mdist = 13'({b0[3:0], i_data_byte}) + 13'd1;
                                    end
                                endcase
                                if (32'(len) > r_rem || mdist > r_pc) begin
                                    n_fstat = lzsd_pkg::ST_BADSIZE;
                                    n_phase = lzsd_pkg::PH_ERROR;
                                    n_copy  = '0;
                                end else begin
                                    n_rem    = r_rem - 32'(len);
                                    n_copy   = len;
                                    n_dist   = mdist;
                                    tok_done = 1'b1;
                                end
                            end else begin
                                if (c == 3'd1) n_tok[15:8] = i_data_byte;
                                else           n_tok[7:0]  = i_data_byte;
                                n_phase = r_phase + 4'd1;
                            end
                        end
                        lzsd_pkg::PH_DONE: begin
                            if (r_trail >= lzsd_pkg::TRAIL_W'(lzsd_pkg::TRAILING_LIMIT)) begin
                                n_fstat = lzsd_pkg::ST_BIG;
                                n_phase = lzsd_pkg::PH_ERROR;
                                n_copy  = '0;
                            end else begin
                                n_trail = r_trail + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // advance to the next token
            if (tok_done) begin
                n_flags = {r_flags[6:0], 1'b0};
                if (r_left != '0) n_left = r_left - 4'd1;
                if (n_rem == '0)       n_phase = lzsd_pkg::PH_DONE;
                else if (n_left != '0) n_phase = lzsd_pkg::PH_TOKEN;
                else                   n_phase = lzsd_pkg::PH_FLAG;
            end

            // end the stream on the final byte
            if (i_last_byte) begin
                n_ended = 1'b1;
                if (n_phase != lzsd_pkg::PH_DONE && n_phase != lzsd_pkg::PH_ERROR) begin
                    n_fstat = lzsd_pkg::ST_SMALL;
                    n_phase = lzsd_pkg::PH_ERROR;
                    n_copy  = '0;
                end
            end
        end

        // one byte into the window
        if (put) begin
            n_wp = r_wp + 1'b1;
            if (r_pc < lzsd_pkg::COUNT_W'(lzsd_pkg::WINDOW_DEPTH)) n_pc = r_pc + 1'b1;
        end
    end

    // hold the decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_pc <= '0; r_rem <= '0; r_phase <= lzsd_pkg::PH_HDR0;
            r_ext <= 1'b0; r_flags <= '0; r_left <= '0; r_tok <= '0; r_copy <= '0;
            r_dist <= '0; r_trail <= '0; r_fstat <= lzsd_pkg::ST_OK; r_ended <= 1'b0;
        end else if (i_fire) begin
            r_wp <= n_wp; r_pc <= n_pc; r_rem <= n_rem; r_phase <= n_phase;
            r_ext <= n_ext; r_flags <= n_flags; r_left <= n_left; r_tok <= n_tok;
            r_copy <= n_copy; r_dist <= n_dist; r_trail <= n_trail;
            r_fstat <= n_fstat; r_ended <= n_ended;
        end
    end

    assign o_res = w_res;

endmodule

// ===== hdl/lz77_stream_decompressor.sv =====
// Output: a result enters the output register in the cycle after its transfer in.
// Throughput: one item per cycle, feeds and pulls alike, while the output register
// is free or being taken; the history RAM has one write and one registered read
// port, and the byte still in the output register is forwarded to a copy that reads it.
// Reset: synchronous, active low; clears the parser and output valid, history
// contents are kept and read only after being written.
module lz77_stream_decompressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzsd_in_if.sink     i_in,
    lzsd_out_if.source  o_out
);

    lzsd_pkg::t_res               w_res;
    logic                         w_fire;
    logic                         w_xfer;
    logic [7:0]                   w_mem_q;
    logic [7:0]                   w_byte;
    logic                         w_fwd;

    logic                         r_valid;
    logic                         r_kind;
    logic [2:0]                   r_status;
    logic [7:0]                   r_lit;
    logic [7:0]                   r_fwd;
    logic [1:0]                   r_src;
    logic [lzsd_pkg::ADDR_W-1:0]  r_waddr;

    assign w_xfer    = r_valid && o_out.ready;
    assign i_in.ready = !r_valid || o_out.ready;
    assign w_fire    = i_in.valid && i_in.ready;

    lzsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_command   (i_in.command),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_res       (w_res)
    );

    // select the byte held in the result register
    always_comb begin
        unique case (r_src)
            lzsd_pkg::SRC_MEM: w_byte = w_mem_q;
            lzsd_pkg::SRC_FWD: w_byte = r_fwd;
            default:           w_byte = r_lit;
        endcase
    end

    // a copy reading the byte not yet written takes it from the result register
    assign w_fwd = r_valid && r_kind == lzsd_pkg::KIND_DATA && r_waddr == w_res.raddr;

    lzsd_hist u_hist (
        .i_clk   (i_clk),
        .i_we    (w_xfer && r_kind == lzsd_pkg::KIND_DATA),
        .i_waddr (r_waddr),
        .i_wdata (w_byte),
        .i_re    (w_fire && w_res.is_copy),
        .i_raddr (w_res.raddr),
        .o_rdata (w_mem_q)
    );

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_fire) begin
            r_valid <= w_res.has_res;
        end else if (w_xfer) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_fire && w_res.has_res) begin
            r_kind   <= w_res.kind;
            r_status <= w_res.status;
            r_lit    <= w_res.lit;
            r_waddr  <= w_res.waddr;
            r_fwd    <= w_byte;
            if (!w_res.is_copy)  r_src <= lzsd_pkg::SRC_LIT;
            else if (w_fwd)      r_src <= lzsd_pkg::SRC_FWD;
            else                 r_src <= lzsd_pkg::SRC_MEM;
        end
    end

    assign o_out.valid  = r_valid;
    assign o_out.kind   = r_kind;
    assign o_out.value  = (r_kind == lzsd_pkg::KIND_DATA) ? w_byte : 8'h00;
    assign o_out.status = (r_kind == lzsd_pkg::KIND_DATA) ? lzsd_pkg::ST_OK : r_status;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == lzsd_pkg::KIND_STATUS |-> r_status <= lzsd_pkg::ST_OVERRUN)
        else $error("status code out of range");

    a_fwd_after_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_res.is_copy && w_fwd |-> i_in.ready && r_kind == lzsd_pkg::KIND_DATA)
        else $error("forward without a pending data byte");

    a_copy_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_res.is_copy |=> r_valid && r_kind == lzsd_pkg::KIND_DATA)
        else $error("copy did not yield a data result");

endmodule

// ===== tb/lzsd_stream_checker.sv =====
module lzsd_stream_checker
    import lzsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lzsd_in_if   i_in,
    lzsd_out_if  i_out,
    output int   o_errors,
    output int   o_pending,
    output int   o_data_seen,
    output int   o_status_seen
);

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic [2:0] status;
    } t_outcome;

    t_outcome outcome_q[$];

    // decoder state mirrored from the block
    logic [7:0]         hist [WINDOW_DEPTH];
    logic [ADDR_W-1:0]  wr_ptr;
    logic [COUNT_W-1:0] produced;
    logic [31:0]        remain;
    logic [3:0]         phase;
    logic               ext_mode;
    logic [7:0]         flags;
    logic [3:0]         flags_left;
    logic [23:0]        tok;
    logic [16:0]        copy_left;
    logic [12:0]        copy_dist;
    logic [TRAIL_W-1:0] trail;
    logic [2:0]         fin_status;
    logic               ended;

    function automatic void restart_stream();
        wr_ptr     = '0;
        produced   = '0;
        remain     = '0;
        phase      = PH_HDR0;
        ext_mode   = 1'b0;
        flags      = '0;
        flags_left = '0;
        tok        = '0;
        copy_left  = '0;
        copy_dist  = '0;
        trail      = '0;
        fin_status = ST_OK;
        ended      = 1'b0;
    endfunction

    function automatic void store_byte(input logic [7:0] v);
        hist[wr_ptr] = v;
        wr_ptr = wr_ptr + 1'b1;
        if (produced < WINDOW_DEPTH)
            produced = produced + 1'b1;
    endfunction

    function automatic void abort(input logic [2:0] code);
        fin_status = code;
        phase      = PH_ERROR;
        copy_left  = '0;
    endfunction

    function automatic void close_token();
        flags = flags << 1;
        if (flags_left > 0)
            flags_left = flags_left - 1'b1;
        if (remain == 0)
            phase = PH_DONE;
        else
            phase = (flags_left != 0) ? PH_TOKEN : PH_FLAG;
    endfunction

    function automatic int token_length(input logic [7:0] b0);
        if (!ext_mode)
            return 2;
        if (b0[7:4] == 4'd1)
            return 4;
        if (b0[7:4] == 4'd0)
            return 3;
        return 2;
    endfunction

    // resolve length and distance of a complete match token
    function automatic void close_match(input int k, input logic [7:0] cur);
        logic [7:0] b [4];
        logic [31:0] len;
        logic [31:0] mdist;
        b[0] = tok[23:16];
        b[1] = tok[15:8];
        b[2] = tok[7:0];
        b[3] = 8'h00;
        b[k-1] = cur;
        if (!ext_mode)
            len = 32'(b[0][7:4]) + 32'd3;
        else if (k == 4)
            len = {16'd0, b[0][3:0], b[1], b[2][7:4]} + 32'h111;
        else if (k == 3)
            len = {24'd0, b[0][3:0], b[1][7:4]} + 32'h11;
        else
            len = 32'(b[0][7:4]) + 32'h01;
        mdist = {20'd0, b[k-2][3:0], b[k-1]} + 32'd1;
        if (len > remain || mdist > 32'(produced)) begin
            abort(ST_BADSIZE);
        end else begin
            remain    = remain - len;
            copy_left = len[16:0];
            copy_dist = mdist[12:0];
            close_token();
        end
    endfunction

    // parse one compressed byte; return 1 when it is a literal to emit
    function automatic bit parse_byte(input logic [7:0] b);
        int k;
        int c;
        if (phase == PH_HDR0) begin
            if (b[7:4] != 4'h1 || b[3:0] > 4'h1) begin
                abort(ST_BADTYPE);
                return 0;
            end
            ext_mode = b[0];
            remain   = '0;
            phase    = PH_HDR1;
        end else if (phase <= PH_HDR3) begin
            remain = remain | (32'(b) << (8 * (phase - PH_HDR1)));
            if (phase < PH_HDR3)
                phase = phase + 1'b1;
            else
                phase = (remain != 0) ? PH_FLAG : PH_EXT0;
        end else if (phase < PH_FLAG) begin
            remain = remain | (32'(b) << (8 * (phase - PH_EXT0)));
            if (phase < PH_EXT3)
                phase = phase + 1'b1;
            else
                phase = (remain != 0) ? PH_FLAG : PH_DONE;
        end else if (phase == PH_FLAG) begin
            flags      = b;
            flags_left = 4'd8;
            phase      = PH_TOKEN;
        end else if (phase == PH_TOKEN) begin
            if (flags[7]) begin
                tok   = {b, 16'h0000};
                phase = PH_MATCH1;
            end else begin
                store_byte(b);
                remain = remain - 1;
                close_token();
                return 1;
            end
        end else if (phase < PH_DONE) begin
            c = phase - PH_TOKEN;
            k = token_length(tok[23:16]);
            if (c + 1 >= k) begin
                close_match(k, b);
            end else begin
                tok   = tok | (24'(b) << (16 - 8 * c));
                phase = phase + 1'b1;
            end
        end else if (phase == PH_DONE) begin
            if (trail >= TRAILING_LIMIT)
                abort(ST_BIG);
            else
                trail = trail + 1'b1;
        end
        return 0;
    endfunction

    // advance the decoder by one transfer; return 1 when a result follows
    function automatic bit decode_step(input logic cmd, input logic [7:0] b,
                                       input logic last, output t_outcome res);
        logic [7:0] v;
        res = '0;
        if (cmd == CMD_PULL) begin
            if (copy_left > 0) begin
                v = hist[wr_ptr - copy_dist[ADDR_W-1:0]];
                store_byte(v);
                copy_left = copy_left - 1'b1;
                res.kind  = KIND_DATA;
                res.value = v;
                return 1;
            end
            if (ended) begin
                res.kind   = KIND_STATUS;
                res.status = fin_status;
                restart_stream();
                return 1;
            end
            return 0;
        end
        if (ended)
            return 0;
        if (phase != PH_ERROR) begin
            if (copy_left > 0) begin
                abort(ST_OVERRUN);
            end else if (parse_byte(b)) begin
                res.kind  = KIND_DATA;
                res.value = b;
                if (last) begin
                    ended = 1'b1;
                    if (phase != PH_DONE && phase != PH_ERROR)
                        abort(ST_SMALL);
                end
                return 1;
            end
        end
        if (last) begin
            ended = 1'b1;
            if (phase != PH_DONE && phase != PH_ERROR)
                abort(ST_SMALL);
        end
        return 0;
    endfunction

    initial begin
        foreach (hist[i])
            hist[i] = 8'h00;
        restart_stream();
        o_errors      = 0;
        o_data_seen   = 0;
        o_status_seen = 0;
    end

    assign o_pending = outcome_q.size();

    // compare output transfers first, then predict from input transfers
    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (!i_rst_n) begin
            restart_stream();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = {i_out.kind, i_out.value, i_out.status};
                if (got.kind == KIND_STATUS)
                    o_status_seen++;
                else
                    o_data_seen++;
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d value=%02h status=%0d",
                             $time, got.kind, got.value, got.status);
                    o_errors++;
                end else begin
                    want = outcome_q.pop_front();
                    if (got.kind != want.kind || got.value != want.value
                            || got.status != want.status) begin
                        $display("%0t: mismatch expected kind=%0d value=%02h status=%0d",
                                 $time, want.kind, want.value, want.status);
                        $display("%0t:          actual   kind=%0d value=%02h status=%0d",
                                 $time, got.kind, got.value, got.status);
                        o_errors++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (decode_step(i_in.command, i_in.data_byte, i_in.last_byte, want))
                    outcome_q.push_back(want);
            end
        end
    end

endmodule

// ===== tb/lz77_stream_decompressor_test.sv =====
module lz77_stream_decompressor_test;
    import lzsd_pkg::*;

    localparam int ITEM_TARGET = 500;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    // stream defects
    localparam int FLAW_NONE     = 0;
    localparam int FLAW_TRUNC    = 1;
    localparam int FLAW_BADTYPE  = 2;
    localparam int FLAW_BADMATCH = 3;
    localparam int FLAW_OVERRUN  = 4;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       last;
    } t_item;

    logic i_clk;
    logic i_rst_n;

    lzsd_in_if  in_ch ();
    lzsd_out_if out_ch ();

    int errors;
    int pending;
    int data_seen;
    int status_seen;

    t_item stim_q[$];
    bit    quiet;
    bit    hold_request;
    int    idle_cycles;

    lz77_stream_decompressor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lzsd_stream_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_data_seen   (data_seen),
        .o_status_seen (status_seen)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_item feed(input logic [7:0] b);
        return '{cmd: CMD_FEED, data: b, last: 1'b0};
    endfunction

    function automatic t_item pull();
        return '{cmd: CMD_PULL, data: 8'($urandom), last: 1'($urandom)};
    endfunction

    // build one compressed stream of the given output size, then its status pull
    task automatic add_stream(input int size, input bit mode1, input bit ext_size,
                              input int trailing, input int flaw);
        logic [7:0] tok_b[$];
        int   tok_start[$];
        int   tok_len[$];
        int   tok_pulls[$];
        bit   tok_match[$];
        int   produced;
        int   rem;
        int   len;
        int   d;
        int   L;
        int   s;
        int   idx;
        int   last_feed;
        bit   overrun_done;
        logic [7:0] b0;
        logic [7:0] flag;
        produced     = 0;
        rem          = size;
        overrun_done = 0;
        // choose tokens
        while (rem > 0) begin
            tok_start.push_back(tok_b.size());
            if (produced > 0 && rem >= 3 && $urandom_range(0, 1)) begin
                d = $urandom_range(0, (produced > 4096 ? 4096 : produced) - 1);
                if (!mode1) begin
                    len = $urandom_range(3, rem < 18 ? rem : 18);
                    tok_b.push_back(8'(((len - 3) << 4) | (d >> 8)));
                    tok_b.push_back(8'(d));
                end else if (rem >= 273 && $urandom_range(0, 3) == 0) begin
                    len = $urandom_range(273, rem < 300 ? rem : 300);
                    L = len - 'h111;
                    tok_b.push_back(8'(8'h10 | (L >> 12)));
                    tok_b.push_back(8'(L >> 4));
                    tok_b.push_back(8'(((L & 15) << 4) | (d >> 8)));
                    tok_b.push_back(8'(d));
                end else if (rem >= 17 && $urandom_range(0, 1)) begin
                    len = $urandom_range(17, rem < 40 ? rem : 40);
                    L = len - 'h11;
                    tok_b.push_back(8'(L >> 4));
                    tok_b.push_back(8'(((L & 15) << 4) | (d >> 8)));
                    tok_b.push_back(8'(d));
                end else begin
                    // short form: a high nibble of two or more, length 3 to 16
                    len = $urandom_range(3, rem < 16 ? rem : 16);
                    tok_b.push_back(8'(((len - 1) << 4) | (d >> 8)));
                    tok_b.push_back(8'(d));
                end
                // point randomly chosen matches past the data produced so far
                if (flaw == FLAW_BADMATCH && $urandom_range(0, 2) == 0 && produced < 4096) begin
                    d = produced;
                    tok_b[tok_b.size() - 2][3:0] = 4'(d >> 8);
                    tok_b[tok_b.size() - 1]      = 8'(d);
                end
                tok_match.push_back(1);
                tok_pulls.push_back(len);
                produced += len;
                rem      -= len;
            end else begin
                tok_b.push_back(8'($urandom));
                tok_match.push_back(0);
                tok_pulls.push_back(0);
                produced++;
                rem--;
            end
            tok_len.push_back(tok_b.size() - tok_start[$]);
        end

        s = stim_q.size();
        // header
        if (flaw == FLAW_BADTYPE) begin
            do b0 = 8'($urandom); while (b0[7:4] == 4'h1 && b0[3:0] <= 4'h1);
        end else begin
            b0 = {4'h1, 3'b000, mode1};
        end
        stim_q.push_back(feed(b0));
        if (ext_size) begin
            repeat (3) stim_q.push_back(feed(8'h00));
            for (int i = 0; i < 4; i++)
                stim_q.push_back(feed(8'(size >> (8 * i))));
        end else begin
            for (int i = 0; i < 3; i++)
                stim_q.push_back(feed(8'(size >> (8 * i))));
        end

        // flag groups with their tokens and copy pulls
        for (int g = 0; g < tok_match.size(); g += 8) begin
            flag = 8'($urandom);
            for (int j = 0; j < 8; j++)
                if (g + j < tok_match.size())
                    flag[7 - j] = tok_match[g + j];
            stim_q.push_back(feed(flag));
            for (int j = g; j < g + 8 && j < tok_match.size(); j++) begin
                for (int n = 0; n < tok_len[j]; n++)
                    stim_q.push_back(feed(tok_b[tok_start[j] + n]));
                if (flaw == FLAW_OVERRUN && tok_match[j] && !overrun_done) begin
                    stim_q.push_back(pull());
                    stim_q.push_back(feed(8'($urandom)));
                    overrun_done = 1;
                end
                for (int n = 0; n < tok_pulls[j]; n++)
                    stim_q.push_back(pull());
            end
        end

        repeat (trailing) stim_q.push_back(feed(8'($urandom)));

        // mark the end of the stream, early when truncated
        last_feed = s;
        for (int i = s; i < stim_q.size(); i++)
            if (stim_q[i].cmd == CMD_FEED)
                last_feed = i;
        idx = last_feed;
        if (flaw == FLAW_TRUNC && last_feed > s) begin
            do idx = $urandom_range(s, last_feed - 1); while (stim_q[idx].cmd != CMD_FEED);
            for (int i = stim_q.size() - 1; i > idx; i--)
                if (stim_q[i].cmd == CMD_FEED)
                    stim_q.delete(i);
        end
        stim_q[idx].last = 1'b1;
        stim_q.push_back(pull());
        if ($urandom_range(0, 4) == 0)
            stim_q.push_back(pull());
    endtask

    task automatic add_noise(input int n);
        repeat (n)
            stim_q.push_back('{cmd: 1'($urandom), data: 8'($urandom),
                               last: ($urandom_range(0, 7) == 0)});
    endtask

    // watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results pending",
                     STALL_LIMIT, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random back-pressure bursts and one long hold-off
    initial begin
        bit held;
        held = 0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request && !held) begin
                held = 1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int noise_items;
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_FEED;
        in_ch.data_byte = 8'h00;
        in_ch.last_byte = 1'b0;
        quiet        = 0;
        hold_request = 0;
        noise_items  = 0;
        i_rst_n      = 1'b0;

        // directed: pull on an idle block, bad type, minimal streams, size zero
        // with too many trailing bytes, bad match and overrun
        stim_q.push_back(pull());
        add_stream(1, 0, 0, 0, FLAW_BADTYPE);
        add_stream(4, 0, 0, 0, FLAW_NONE);
        add_stream(3, 1, 1, 0, FLAW_NONE);
        add_stream(0, 0, 1, 33, FLAW_NONE);
        add_stream(5, 1, 0, 1, FLAW_BADMATCH);
        add_stream(5, 0, 0, 0, FLAW_OVERRUN);
        stim_q.push_back(feed(8'hff));
        stim_q.push_back(feed(8'h00));

        // random: mostly well-formed streams, some defects and noise; long
        // streams only early so the total stays near the target
        while (stim_q.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                add_noise($urandom_range(1, 6));
            end else begin
                add_stream(($urandom_range(0, 24) == 0 && stim_q.size() < ITEM_TARGET / 4)
                               ? $urandom_range(274, 300) : $urandom_range(1, 24),
                           1'($urandom), ($urandom_range(0, 5) == 0),
                           ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34)
                                                       : $urandom_range(0, 3),
                           ($urandom_range(0, 9) < 7) ? FLAW_NONE
                                                      : $urandom_range(FLAW_TRUNC,
                                                                       FLAW_OVERRUN));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drive each item at the falling edge and hold it until transfer
        @(negedge i_clk);
        foreach (stim_q[i]) begin
            quiet = (i > stim_q.size() * 9 / 10);
            if (i == stim_q.size() / 2)
                hold_request = 1;
            if (!quiet && $urandom_range(0, 5) == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            in_ch.valid     <= 1'b1;
            in_ch.command   <= stim_q[i].cmd;
            in_ch.data_byte <= stim_q[i].data;
            in_ch.last_byte <= stim_q[i].last;
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d transfers in; checked %0d data bytes and %0d stream statuses.",
                 stim_q.size(), data_seen, status_seen);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== lz77_stream_decompressor.f =====
hdl/lzsd_pkg.sv
hdl/lzsd_in_if.sv
hdl/lzsd_out_if.sv
hdl/lzsd_hist.sv
hdl/lzsd_ctrl.sv
hdl/lz77_stream_decompressor.sv
tb/lzsd_stream_checker.sv
tb/lz77_stream_decompressor_test.sv
